// ===== src/uvei_pkg.sv =====
// uvei_pkg: shared types and constants for the undervoltage event integrator
// no dependencies; used by uvei_event_if, uvei_core and the top level
`default_nettype none

package uvei_pkg;

  localparam int EVENT_BITS     = 16;
  localparam int WRAP_BITS      = 17;
  localparam int PERIOD_BITS    = 16;
  localparam int CFG_DATA_BITS  = 17;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_TIMER_WRAP   = 2'd0,
    CFG_RESET_DELAY  = 2'd1,
    CFG_LONG_PERIOD  = 2'd2,
    CFG_SHORT_PERIOD = 2'd3
  } uvei_cfg_index_t;

  localparam logic [WRAP_BITS-1:0]   TIMER_WRAP_RESET   = 17'd65536;
  localparam logic [PERIOD_BITS-1:0] RESET_DELAY_RESET  = 16'd100;
  localparam logic [PERIOD_BITS-1:0] LONG_PERIOD_RESET  = 16'd1000;
  localparam logic [PERIOD_BITS-1:0] SHORT_PERIOD_RESET = 16'd100;

  // count*10 > 8*elapsed/100 is the same test as count*1000 > 8*elapsed
  localparam int DENSITY_SCALE  = 1000;
  localparam int DENSITY_EVENTS = 8;
  // count+1 > short/10 is the same test as (count+1)*10 > short
  localparam int WINDOW_DIV     = 10;

  typedef struct packed {
    logic [WRAP_BITS-1:0]   timer_wrap;
    logic [PERIOD_BITS-1:0] reset_delay;
    logic [PERIOD_BITS-1:0] long_period;
    logic [PERIOD_BITS-1:0] short_period;
  } uvei_cfg_t;

  typedef struct packed {
    logic                  fire;
    logic [EVENT_BITS-1:0] event_time;
  } uvei_step_t;

  typedef struct packed {
    logic supply_sag;
    logic supply_fail;
  } uvei_flags_t;

endpackage

`default_nettype wire

// ===== src/uvei_event_if.sv =====
// uvei_event_if: valid/ready channel carrying one undervoltage event time stamp
// depends on uvei_pkg
`default_nettype none

interface uvei_event_if import uvei_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [EVENT_BITS-1:0] event_time;

  modport source (output valid, output event_time, input ready);
  modport sink   (input valid, input event_time, output ready);
endinterface

`default_nettype wire

// ===== src/uvei_result_if.sv =====
// uvei_result_if: valid/ready channel carrying the two integrator flags per event
// no dependencies
`default_nettype none

interface uvei_result_if ();
  logic valid;
  logic ready;
  logic supply_sag;
  logic supply_fail;

  modport source (output valid, output supply_sag, output supply_fail, input ready);
  modport sink   (input valid, input supply_sag, input supply_fail, output ready);
endinterface

`default_nettype wire

// ===== src/uvei_core.sv =====
// uvei_core: slow and fast integrator state and the single-pass event evaluation
// depends on uvei_pkg
`default_nettype none

module uvei_core import uvei_pkg::*; #(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  uvei_cfg_t   cfg,
  input  uvei_step_t  step,
  output uvei_flags_t flags
);

  localparam int EW = (TIME_BITS > WRAP_BITS) ? TIME_BITS : WRAP_BITS;
  localparam int SW = ((TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS) + 1;
  localparam int PW = (COUNT_BITS + 10 > TIME_BITS + 3) ? COUNT_BITS + 10 : TIME_BITS + 3;
  localparam int QW = (COUNT_BITS + 5 > PERIOD_BITS) ? COUNT_BITS + 5 : PERIOD_BITS;

  localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic [TIME_BITS-1:0]  slow_start, slow_start_next;
  logic [TIME_BITS-1:0]  fast_start, fast_start_next;
  logic [COUNT_BITS-1:0] slow_count, slow_count_next;
  logic [COUNT_BITS-1:0] fast_count, fast_count_next;
  logic [TIME_BITS-1:0]  last_slow_elapsed, last_slow_elapsed_next;

  logic [TIME_BITS-1:0]  now;
  logic [TIME_BITS-1:0]  slow_el;
  logic [TIME_BITS-1:0]  fast_el;
  logic [COUNT_BITS-1:0] fast_base;

  // elapsed time across the timer wrap, saturating
  function automatic logic [TIME_BITS-1:0] elapsed(
    input logic [TIME_BITS-1:0] now_t,
    input logic [TIME_BITS-1:0] start_t,
    input logic [WRAP_BITS-1:0] wrap
  );
    logic [EW-1:0] gap;
    logic [EW-1:0] e;
    gap = '0;
    if (now_t >= start_t) begin
      e = EW'(now_t - start_t);
    end else begin
      gap = EW'(start_t - now_t);
      e = (EW'(wrap) >= gap) ? (EW'(wrap) - gap) : '0;
    end
    return (e > EW'(TIME_MAX)) ? TIME_MAX : e[TIME_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_ONE;
  endfunction

  assign now     = TIME_BITS'(step.event_time);
  assign slow_el = elapsed(now, slow_start, cfg.timer_wrap);
  assign fast_el = elapsed(now, fast_start, cfg.timer_wrap);

  always_comb begin
    slow_start_next        = slow_start;
    fast_start_next        = fast_start;
    slow_count_next        = slow_count;
    fast_count_next        = fast_count;
    last_slow_elapsed_next = last_slow_elapsed;
    fast_base              = fast_count;
    flags                  = '0;

    if (slow_count == '0) begin
      slow_count_next        = COUNT_ONE;
      slow_start_next        = now;
      last_slow_elapsed_next = '0;
    end else if (SW'(slow_el) > SW'(cfg.reset_delay) + SW'(last_slow_elapsed)) begin
      // gap too long: restart slow, and the fast integrator restarts on this event too
      slow_count_next        = COUNT_ONE;
      slow_start_next        = now;
      last_slow_elapsed_next = '0;
      fast_base              = '0;
    end else begin
      slow_count_next = count_up(slow_count);
      if (SW'(slow_el) > SW'(cfg.long_period)) begin
        flags.supply_sag = (PW'(slow_count_next) * PW'(DENSITY_SCALE))
                           > (PW'(slow_el) * PW'(DENSITY_EVENTS));
      end
      last_slow_elapsed_next = slow_el;
    end

    if (fast_base == '0) begin
      fast_count_next = COUNT_ONE;
      fast_start_next = now;
    end else begin
      fast_count_next = count_up(fast_base);
      if (SW'(fast_el) > SW'(cfg.short_period)) begin
        flags.supply_fail = ((QW'(fast_count_next) + QW'(1)) * QW'(WINDOW_DIV))
                            > QW'(cfg.short_period);
        fast_count_next = COUNT_ONE;
        fast_start_next = now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_start        <= '0;
      fast_start        <= '0;
      slow_count        <= '0;
      fast_count        <= '0;
      last_slow_elapsed <= '0;
    end else if (step.fire) begin
      slow_start        <= slow_start_next;
      fast_start        <= fast_start_next;
      slow_count        <= slow_count_next;
      fast_count        <= fast_count_next;
      last_slow_elapsed <= last_slow_elapsed_next;
    end
  end

  a_counts_live: assert property (@(posedge clk) disable iff (rst)
    step.fire |=> (slow_count != '0) && (fast_count != '0))
    else $error("integrator count left at zero after an event");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !step.fire |=> $stable(slow_count) && $stable(fast_count)
                           && $stable(slow_start) && $stable(fast_start))
    else $error("integrator state changed without an event");

  a_fast_restart: assert property (@(posedge clk) disable iff (rst)
    step.fire && flags.supply_fail |=> fast_count == COUNT_ONE)
    else $error("fast window did not restart after a fault check");

endmodule

`default_nettype wire

// ===== src/undervoltage_event_integrator_top.sv =====
// undervoltage_event_integrator_top: event input stage, result register and config regs
// depends on uvei_pkg, uvei_event_if, uvei_result_if and uvei_core
`default_nettype none

// One event can be taken per clock while results.ready stays high. An accepted event sits
// in the input register while uvei_core evaluates both integrators in a single
// combinational pass and updates their state; the flags land in the result register,
// which offers the result until it is taken. While a result waits to be taken, the input
// register holds one more event and events.ready then stays low until the result is taken.
// The user must write the registers through cfg_write, cfg_index and cfg_data only while
// no event is in flight; the block itself does not enforce it. They have no read-back.
module undervoltage_event_integrator_top import uvei_pkg::*; #(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  uvei_event_if.sink                events,
  uvei_result_if.source             results
);

  uvei_cfg_t             cfg;
  logic                  ev_valid;
  logic [EVENT_BITS-1:0] ev_time;
  logic                  res_valid;
  uvei_flags_t           res_flags;
  uvei_flags_t           flags;
  uvei_step_t            step;
  logic                  advance;

  assign advance         = !res_valid || results.ready;
  assign events.ready    = !ev_valid || advance;
  assign step.fire       = ev_valid && advance;
  assign step.event_time = ev_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_wrap   <= TIMER_WRAP_RESET;
      cfg.reset_delay  <= RESET_DELAY_RESET;
      cfg.long_period  <= LONG_PERIOD_RESET;
      cfg.short_period <= SHORT_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (uvei_cfg_index_t'(cfg_index))
        CFG_TIMER_WRAP:   cfg.timer_wrap   <= cfg_data;
        CFG_RESET_DELAY:  cfg.reset_delay  <= cfg_data[PERIOD_BITS-1:0];
        CFG_LONG_PERIOD:  cfg.long_period  <= cfg_data[PERIOD_BITS-1:0];
        CFG_SHORT_PERIOD: cfg.short_period <= cfg_data[PERIOD_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (events.ready) begin
      ev_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      ev_time <= events.event_time;
    end
  end

  uvei_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .step  (step),
    .flags (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      res_flags <= flags;
    end
  end

  assign results.valid       = res_valid;
  assign results.supply_sag  = res_flags.supply_sag;
  assign results.supply_fail = res_flags.supply_fail;

  a_stage_free: assert property (@(posedge clk) disable iff (rst)
    !ev_valid |-> events.ready)
    else $error("input stage empty but not ready");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && ev_valid && !advance |=> ev_valid && $stable(ev_time))
    else $error("stalled event lost from input stage");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    !rst && step.fire |=> res_valid)
    else $error("evaluated event produced no result");

endmodule

`default_nettype wire

// ===== sim/undervoltage_event_integrator_top_tb.sv =====
// testbench for undervoltage_event_integrator_top: event stamps in, supply_sag/supply_fail out
// a clocked driver and monitors check each result against a local integrator model
// depends on uvei_pkg, uvei_event_if, uvei_result_if and the top level
`timescale 1ns / 1ps

module undervoltage_event_integrator_top_tb;
  import uvei_pkg::*;

  localparam longint unsigned TIME_MAX    = 64'hFFFF;
  localparam longint unsigned COUNT_MAX   = 64'hFFFF;
  localparam longint unsigned COUNT_SCALE = 10;
  localparam longint unsigned DROP_RATE   = 8;
  localparam longint unsigned ELAPSED_DIV = 100;
  localparam int              HOLD_CYCLES = 400;
  localparam int              CHUNK_ITEMS = 30;
  localparam int              DENSE_GAP   = 12;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  uvei_event_if  ev_ch ();
  uvei_result_if res_ch ();

  undervoltage_event_integrator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .events    (ev_ch),
    .results   (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copies
  longint unsigned wrap_ms;
  longint unsigned restart_gap;
  longint unsigned long_ms;
  longint unsigned short_ms;

  // integrator state
  longint unsigned slow_mark, fast_mark;
  longint unsigned slow_events, fast_events;
  longint unsigned slow_prev_el;

  logic [EVENT_BITS-1:0] pending_stamps[$];
  uvei_flags_t           expected_flags[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int          errors;

  bit          hold_armed;
  bit          hold_done;
  int unsigned hold_left;

  // stimulus generator state
  longint unsigned stamp_cursor;
  int unsigned     burst_left;
  longint unsigned burst_lim;

  function automatic longint unsigned elapsed_ms(input longint unsigned now_t,
                                                 input longint unsigned start_t);
    longint unsigned e;
    longint unsigned gap;
    if (now_t >= start_t) begin
      e = now_t - start_t;
    end else begin
      gap = start_t - now_t;
      e = (wrap_ms >= gap) ? (wrap_ms - gap) : 0;
    end
    return (e > TIME_MAX) ? TIME_MAX : e;
  endfunction

  function automatic longint unsigned bump(input longint unsigned c);
    return (c >= COUNT_MAX) ? COUNT_MAX : c + 1;
  endfunction

  function automatic uvei_flags_t integrate_event(input logic [EVENT_BITS-1:0] stamp);
    longint unsigned now_t;
    longint unsigned slow_el;
    longint unsigned fast_el;
    uvei_flags_t     f;
    now_t   = stamp;
    slow_el = elapsed_ms(now_t, slow_mark);
    fast_el = elapsed_ms(now_t, fast_mark);
    f = '0;

    if (slow_events == 0) begin
      slow_events  = 1;
      slow_mark    = now_t;
      slow_prev_el = 0;
    end else if (slow_el > restart_gap + slow_prev_el) begin
      // slow restart also restarts the fast window on this event
      slow_mark    = now_t;
      slow_prev_el = 0;
      slow_events  = 1;
      fast_events  = 0;
    end else begin
      slow_events = bump(slow_events);
      if (slow_el > long_ms &&
          slow_events * COUNT_SCALE > (DROP_RATE * slow_el) / ELAPSED_DIV) begin
        f.supply_sag = 1'b1;
      end
      slow_prev_el = slow_el;
    end

    if (fast_events == 0) begin
      fast_events = 1;
      fast_mark   = now_t;
    end else begin
      fast_events = bump(fast_events);
      if (fast_el > short_ms) begin
        if (fast_events + 1 > short_ms / WINDOW_DIV) begin
          f.supply_fail = 1'b1;
        end
        fast_events = 1;
        fast_mark   = now_t;
      end
    end
    return f;
  endfunction

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      ev_ch.valid      <= 1'b0;
      ev_ch.event_time <= '0;
    end else if (!ev_ch.valid || ev_ch.ready) begin
      if (pending_stamps.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        ev_ch.valid      <= 1'b1;
        ev_ch.event_time <= pending_stamps.pop_front();
      end else begin
        ev_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // predict on every event transfer
  always @(posedge clk) begin
    if (!rst && ev_ch.valid && ev_ch.ready) begin
      expected_flags.push_back(integrate_event(ev_ch.event_time));
    end
  end

  // check every result transfer
  always @(posedge clk) begin
    uvei_flags_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_flags.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual supply_sag %0b supply_fail %0b",
                 $time, res_ch.supply_sag, res_ch.supply_fail);
      end else begin
        want = expected_flags.pop_front();
        if (res_ch.supply_sag !== want.supply_sag) begin
          errors++;
          $display("%0t: supply_sag expected %0b actual %0b",
                   $time, want.supply_sag, res_ch.supply_sag);
        end
        if (res_ch.supply_fail !== want.supply_fail) begin
          errors++;
          $display("%0t: supply_fail expected %0b actual %0b",
                   $time, want.supply_fail, res_ch.supply_fail);
        end
      end
    end
  end

  task automatic wait_sent();
    @(negedge clk);
    while (pending_stamps.size() != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_stamps.size() != 0 || ev_ch.valid || expected_flags.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input uvei_cfg_index_t idx, input longint unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_BITS-1:0];
    case (idx)
      CFG_TIMER_WRAP:   wrap_ms     = val & 64'h1FFFF;
      CFG_RESET_DELAY:  restart_gap = val & 64'hFFFF;
      CFG_LONG_PERIOD:  long_ms     = val & 64'hFFFF;
      CFG_SHORT_PERIOD: short_ms    = val & 64'hFFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_setting(input longint unsigned wrap, input longint unsigned gap,
                               input longint unsigned lp, input longint unsigned sp);
    wait_idle();
    write_reg(CFG_TIMER_WRAP, wrap);
    write_reg(CFG_RESET_DELAY, gap);
    write_reg(CFG_LONG_PERIOD, lp);
    write_reg(CFG_SHORT_PERIOD, sp);
    stamp_cursor = stamp_cursor % wrap_ms;
  endtask

  // runs of closely spaced events, broken by long gaps or stray stamps
  task automatic queue_bursts(input int count);
    longint unsigned stamp;
    int              k;
    for (k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(80, 4);
        if ($urandom_range(1) != 0) begin
          burst_lim = restart_gap;
        end else begin
          burst_lim = (restart_gap < DENSE_GAP) ? restart_gap : DENSE_GAP;
        end
        if ($urandom_range(2) == 0) begin
          stamp = $urandom_range(16'hFFFF);
        end else begin
          stamp = (stamp_cursor + restart_gap + 1 + $urandom_range(300)) % wrap_ms;
        end
      end else if ($urandom_range(99) < 3) begin
        stamp = $urandom_range(16'hFFFF);
      end else begin
        stamp = (stamp_cursor + $urandom_range(burst_lim)) % wrap_ms;
      end
      burst_left--;
      stamp_cursor = stamp % wrap_ms;
      pending_stamps.push_back(stamp[EVENT_BITS-1:0]);
    end
  endtask

  task automatic run_modes(input bit with_hold);
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    int          m;
    idle_tab  = '{0, 45, 0, 12};
    stall_tab = '{0, 0, 45, 12};
    for (m = 0; m < 4; m++) begin
      @(negedge clk);
      sender_idle_pct    = idle_tab[m];
      receiver_stall_pct = stall_tab[m];
      if (with_hold && m == 0) hold_armed = 1'b1;
      queue_bursts(CHUNK_ITEMS);
      wait_sent();
    end
  endtask

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int k;
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= CFG_TIMER_WRAP;
    cfg_data         <= '0;

    wrap_ms      = TIMER_WRAP_RESET;
    restart_gap  = RESET_DELAY_RESET;
    long_ms      = LONG_PERIOD_RESET;
    short_ms     = SHORT_PERIOD_RESET;
    slow_mark    = 0;
    fast_mark    = 0;
    slow_events  = 0;
    fast_events  = 0;
    slow_prev_el = 0;
    errors       = 0;
    hold_armed   = 1'b0;
    stamp_cursor = 0;
    burst_left   = 0;
    burst_lim    = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: wrap across the top, restarts, one dense fast window
    @(negedge clk);
    pending_stamps.push_back(16'hFFFF);
    pending_stamps.push_back(16'h0000);
    pending_stamps.push_back(16'h0005);
    pending_stamps.push_back(16'hAAAA);
    pending_stamps.push_back(16'h5555);
    for (k = 1; k <= 16; k++) pending_stamps.push_back(EVENT_BITS'(16'h5555 + k * 7));
    stamp_cursor = 16'h5555 + 16 * 7;
    run_modes(1'b1);

    // lowest settings: wrap of 2 above a zero gap, stamps above the wrap, tiny window
    apply_setting(2, 0, 0, 0);
    @(negedge clk);
    pending_stamps.push_back(16'd1000);
    pending_stamps.push_back(16'd10);
    pending_stamps.push_back(16'h8000);
    pending_stamps.push_back(16'd1);
    run_modes(1'b0);

    apply_setting(TIMER_WRAP_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_modes(1'b0);

    // window below ten with a short density period
    apply_setting(1000, 60, 300, 9);
    run_modes(1'b0);

    apply_setting($urandom_range(65536, 200), $urandom_range(400, 20),
                  $urandom_range(1500, 100), $urandom_range(150, 10));
    run_modes(1'b0);

    apply_setting($urandom_range(65536, 2), $urandom_range(400, 0),
                  $urandom_range(800, 0), $urandom_range(200, 0));
    run_modes(1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_flags.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
